FILE: rtl/core/ilt_pkg.sv
// ----------------------------------------------------------------------------
// ilt_pkg: shared types and constants of the INI line tokenizer
// Limits, character codes, line phases, result codes and the result struct.
// ----------------------------------------------------------------------------
package ilt_pkg;

  localparam int MAX_SECTIONS = 16;
  localparam int MAX_PAIRS    = 32;
  localparam int NAME_LIMIT   = 32;
  localparam int KEY_LIMIT    = 32;
  localparam int VALUE_LIMIT  = 128;
  localparam int LINE_LIMIT   = 256;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 7;
  localparam int SEC_SLOT_W = 4;
  localparam int PAIR_SLOT_W = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int SEC_W      = $clog2(MAX_SECTIONS + 1);
  localparam int PAIR_W     = $clog2(MAX_PAIRS + 1);
  localparam int COL_W      = $clog2(LINE_LIMIT);
  localparam int FO_W       = 8;

  localparam logic [FO_W-1:0]  FO_MAX   = '1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_LIMIT - 1);

  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COMMENT_A = 2'd0,
    CFG_COMMENT_B = 2'd1,
    CFG_SECT_OPEN = 2'd2,
    CFG_SECT_CLOSE = 2'd3
  } ilt_cfg_idx_e;

  typedef enum logic [2:0] {
    PH_LEAD      = 3'd0,
    PH_SKIP      = 3'd1,
    PH_SECT      = 3'd2,
    PH_SECT_DONE = 3'd3,
    PH_KEY       = 3'd4,
    PH_BAD       = 3'd5,
    PH_VAL       = 3'd6,
    PH_VAL_DONE  = 3'd7
  } ilt_phase_e;

  typedef enum logic [1:0] {
    ROLE_NONE  = 2'd0,
    ROLE_SECT  = 2'd1,
    ROLE_KEY   = 2'd2,
    ROLE_VALUE = 2'd3
  } ilt_role_e;

  typedef enum logic [2:0] {
    KIND_SKIPPED   = 3'd0,
    KIND_SECT_OK   = 3'd1,
    KIND_SECT_DROP = 3'd2,
    KIND_PAIR_OK   = 3'd3,
    KIND_PAIR_DROP = 3'd4,
    KIND_NO_SECT   = 3'd5,
    KIND_MALFORMED = 3'd6
  } ilt_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] comment_a;
    logic [BYTE_W-1:0] comment_b;
    logic [BYTE_W-1:0] sect_open;
    logic [BYTE_W-1:0] sect_close;
  } ilt_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      byte_out;
    ilt_role_e              role;
    logic [POS_W-1:0]       position;
    logic [SEC_SLOT_W-1:0]  sect_slot;
    logic [PAIR_SLOT_W-1:0] pair_slot;
    logic                   line_done;
    ilt_kind_e              kind;
    logic                   text_done;
  } ilt_result_t;

endpackage

FILE: rtl/core/ilt_cfg_regs.sv
// ----------------------------------------------------------------------------
// ilt_cfg_regs: configuration registers
// Comment and section delimiter characters, written by index.
// ----------------------------------------------------------------------------
module ilt_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ilt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ilt_pkg::BYTE_W-1:0]      cfg_wdata_i,
  output ilt_pkg::ilt_cfg_t               cfg_o
);

  ilt_pkg::ilt_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ilt_pkg::ilt_cfg_idx_e'(cfg_idx_i))
        ilt_pkg::CFG_COMMENT_A:  cfg_d.comment_a  = cfg_wdata_i;
        ilt_pkg::CFG_COMMENT_B:  cfg_d.comment_b  = cfg_wdata_i;
        ilt_pkg::CFG_SECT_OPEN:  cfg_d.sect_open  = cfg_wdata_i;
        ilt_pkg::CFG_SECT_CLOSE: cfg_d.sect_close = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.comment_a  <= 8'd59;
      cfg_q.comment_b  <= 8'd35;
      cfg_q.sect_open  <= 8'd91;
      cfg_q.sect_close <= 8'd93;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/ilt_step.sv
// ----------------------------------------------------------------------------
// ilt_step: tokenizer state and per-byte step logic
// Holds the line state and section/pair counters; computes the result for
// the byte presented and advances the state when the byte is retired.
// ----------------------------------------------------------------------------
module ilt_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [ilt_pkg::BYTE_W-1:0]  text_byte_i,
  input  logic                        end_of_text_i,
  input  ilt_pkg::ilt_cfg_t           cfg_i,
  output ilt_pkg::ilt_result_t        result_o
);

  ilt_pkg::ilt_phase_e             phase_q, phase_d;
  logic [ilt_pkg::COL_W-1:0]       col_q, col_d;
  logic [ilt_pkg::FO_W-1:0]        fo_q, fo_d;
  logic                            quote_q, quote_d;
  logic                            bslash_q, bslash_d;
  logic [ilt_pkg::SEC_W-1:0]       sects_q, sects_d;
  logic [ilt_pkg::PAIR_W-1:0]      pairs_q, pairs_d;
  logic                            present_q, present_d;

  logic [ilt_pkg::BYTE_W-1:0]      b;
  logic                            sect_ok, pair_room, is_comment, key_act, done;
  logic [ilt_pkg::SEC_W-1:0]       cur_sec;
  logic                            fc_en, fc_keep;
  ilt_pkg::ilt_role_e              fc_role;
  logic [ilt_pkg::FO_W-1:0]        fc_limit;
  logic [ilt_pkg::SEC_W-1:0]       fc_sec;
  logic [ilt_pkg::PAIR_W-1:0]      fc_pair;
  ilt_pkg::ilt_result_t            res;

  assign b          = text_byte_i;
  assign sect_ok    = sects_q < ilt_pkg::SEC_W'(ilt_pkg::MAX_SECTIONS);
  assign pair_room  = present_q && (pairs_q < ilt_pkg::PAIR_W'(ilt_pkg::MAX_PAIRS));
  assign cur_sec    = present_q ? sects_q - ilt_pkg::SEC_W'(1) : '0;
  assign is_comment = (b == cfg_i.comment_a) || (b == cfg_i.comment_b);

  always_comb begin
    phase_d   = phase_q;
    col_d     = col_q;
    fo_d      = fo_q;
    quote_d   = quote_q;
    bslash_d  = bslash_q;
    sects_d   = sects_q;
    pairs_d   = pairs_q;
    present_d = present_q;
    fc_en     = 1'b0;
    fc_keep   = 1'b0;
    fc_role   = ilt_pkg::ROLE_NONE;
    fc_limit  = '0;
    fc_sec    = '0;
    fc_pair   = '0;
    key_act   = 1'b0;

    res           = '0;
    res.byte_out  = b;
    res.role      = ilt_pkg::ROLE_NONE;
    res.kind      = ilt_pkg::KIND_SKIPPED;
    res.text_done = end_of_text_i;

    case (phase_q)
      ilt_pkg::PH_LEAD: begin
        if (b inside {ilt_pkg::CH_SPACE, ilt_pkg::CH_TAB}) begin
          phase_d = ilt_pkg::PH_LEAD;
        end else if (b == ilt_pkg::CH_NL || b == ilt_pkg::CH_NUL || is_comment) begin
          phase_d = ilt_pkg::PH_SKIP;
        end else if (b == cfg_i.sect_open) begin
          phase_d = ilt_pkg::PH_SECT;
          fo_d    = '0;
        end else begin
          phase_d = ilt_pkg::PH_KEY;
          key_act = 1'b1;
        end
      end
      ilt_pkg::PH_SECT: begin
        if (b == ilt_pkg::CH_NUL || b == cfg_i.sect_close) begin
          phase_d = ilt_pkg::PH_SECT_DONE;
        end else if (b != ilt_pkg::CH_NL) begin
          fc_en    = 1'b1;
          fc_role  = ilt_pkg::ROLE_SECT;
          fc_keep  = sect_ok;
          fc_limit = ilt_pkg::FO_W'(ilt_pkg::NAME_LIMIT);
          fc_sec   = sects_q;
        end
      end
      ilt_pkg::PH_KEY: key_act = 1'b1;
      ilt_pkg::PH_VAL: begin
        if (b == ilt_pkg::CH_NL) begin
          phase_d = ilt_pkg::PH_VAL;
        end else if (b == ilt_pkg::CH_NUL) begin
          phase_d = ilt_pkg::PH_VAL_DONE;
        end else if (bslash_q && b == ilt_pkg::CH_QUOTE) begin
          bslash_d = 1'b0;
          fc_en    = 1'b1;
        end else if (b == ilt_pkg::CH_QUOTE) begin
          quote_d  = !quote_q;
          bslash_d = 1'b0;
          fc_en    = 1'b1;
        end else if (is_comment && !quote_q) begin
          phase_d = ilt_pkg::PH_VAL_DONE;
        end else begin
          bslash_d = (b == ilt_pkg::CH_BSLASH);
          fc_en    = 1'b1;
        end
        fc_role  = ilt_pkg::ROLE_VALUE;
        fc_keep  = pair_room;
        fc_limit = ilt_pkg::FO_W'(ilt_pkg::VALUE_LIMIT);
        fc_sec   = cur_sec;
        fc_pair  = pairs_q;
      end
      default: phase_d = phase_q;
    endcase

    if (key_act) begin
      if (b == ilt_pkg::CH_NUL) begin
        phase_d = ilt_pkg::PH_BAD;
      end else if (b == ilt_pkg::CH_EQ) begin
        phase_d  = ilt_pkg::PH_VAL;
        fo_d     = '0;
        quote_d  = 1'b0;
        bslash_d = 1'b0;
      end else if (b != ilt_pkg::CH_NL) begin
        fc_en    = 1'b1;
        fc_role  = ilt_pkg::ROLE_KEY;
        fc_keep  = pair_room;
        fc_limit = ilt_pkg::FO_W'(ilt_pkg::KEY_LIMIT);
        fc_sec   = cur_sec;
        fc_pair  = pairs_q;
      end
    end

    // field character; offset is zero on entry from line start
    if (fc_en) begin
      if (fc_keep && fo_q < fc_limit) begin
        res.role      = fc_role;
        res.position  = ilt_pkg::POS_W'(fo_q);
        res.sect_slot = ilt_pkg::SEC_SLOT_W'(fc_sec);
        res.pair_slot = ilt_pkg::PAIR_SLOT_W'(fc_pair);
      end
      if (fo_q != ilt_pkg::FO_MAX) begin
        fo_d = fo_q + ilt_pkg::FO_W'(1);
      end
    end

    done = (b == ilt_pkg::CH_NL) || (col_q == ilt_pkg::COL_LAST) || end_of_text_i;
    res.line_done = done;

    if (done) begin
      res.sect_slot = '0;
      res.pair_slot = '0;
      case (phase_d)
        ilt_pkg::PH_SECT, ilt_pkg::PH_SECT_DONE: begin
          if (sect_ok) begin
            res.kind      = ilt_pkg::KIND_SECT_OK;
            res.sect_slot = ilt_pkg::SEC_SLOT_W'(sects_q);
            sects_d       = sects_q + ilt_pkg::SEC_W'(1);
            present_d     = 1'b1;
            pairs_d       = '0;
          end else begin
            res.kind = ilt_pkg::KIND_SECT_DROP;
          end
        end
        ilt_pkg::PH_KEY, ilt_pkg::PH_BAD: res.kind = ilt_pkg::KIND_MALFORMED;
        ilt_pkg::PH_VAL, ilt_pkg::PH_VAL_DONE: begin
          if (!present_q) begin
            res.kind = ilt_pkg::KIND_NO_SECT;
          end else if (pair_room) begin
            res.kind      = ilt_pkg::KIND_PAIR_OK;
            res.sect_slot = ilt_pkg::SEC_SLOT_W'(cur_sec);
            res.pair_slot = ilt_pkg::PAIR_SLOT_W'(pairs_q);
            pairs_d       = pairs_q + ilt_pkg::PAIR_W'(1);
          end else begin
            res.kind      = ilt_pkg::KIND_PAIR_DROP;
            res.sect_slot = ilt_pkg::SEC_SLOT_W'(cur_sec);
          end
        end
        default: res.kind = ilt_pkg::KIND_SKIPPED;
      endcase
      phase_d  = ilt_pkg::PH_LEAD;
      col_d    = '0;
      fo_d     = '0;
      quote_d  = 1'b0;
      bslash_d = 1'b0;
      if (end_of_text_i) begin
        sects_d   = '0;
        pairs_d   = '0;
        present_d = 1'b0;
      end
    end else begin
      col_d = col_q + ilt_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ilt_pkg::PH_LEAD;
      col_q     <= '0;
      fo_q      <= '0;
      quote_q   <= 1'b0;
      bslash_q  <= 1'b0;
      sects_q   <= '0;
      pairs_q   <= '0;
      present_q <= 1'b0;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      col_q     <= col_d;
      fo_q      <= fo_d;
      quote_q   <= quote_d;
      bslash_q  <= bslash_d;
      sects_q   <= sects_d;
      pairs_q   <= pairs_d;
      present_q <= present_d;
    end
  end

  assign result_o = res;

endmodule

FILE: rtl/core/ini_line_tokenizer_top.sv
// ----------------------------------------------------------------------------
// ini_line_tokenizer_top: INI text byte tokenizer
// Tags each text byte with its role, field offset and slots, and reports the
// kind of each line on its last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one text byte per
//   transaction, with end_of_text_i set on the last byte of the text.
//   Output channel: out_valid_o / out_stall_i carry one result per byte,
//   in input order.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 comment char a, 1 comment char b, 2 section open, 3 section close).
//   Write only while no transaction is in flight.
//   Each accepted byte passes the input register, then the result register.
//   Throughput: one byte per cycle while out_stall_i is low; the input
//   register, step logic and result register form a two-stage pipeline.
//   Stall: when out_stall_i holds a result, one more byte is taken into the
//   input register if it is empty, and then in_stall_o rises until the result leaves.
//   Reset: all line state and counters clear, the delimiter registers return
//   to ';', '#', '[' and ']', and both channels are empty.
// ----------------------------------------------------------------------------
module ini_line_tokenizer_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ilt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ilt_pkg::BYTE_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ilt_pkg::BYTE_W-1:0]         text_byte_i,
  input  logic                               end_of_text_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ilt_pkg::BYTE_W-1:0]         byte_out_o,
  output logic [1:0]                         byte_role_o,
  output logic [ilt_pkg::POS_W-1:0]          byte_position_o,
  output logic [ilt_pkg::SEC_SLOT_W-1:0]     section_slot_o,
  output logic [ilt_pkg::PAIR_SLOT_W-1:0]    pair_slot_o,
  output logic                               line_done_o,
  output logic [2:0]                         line_kind_o,
  output logic                               text_done_o
);

  ilt_pkg::ilt_cfg_t          cfg;
  ilt_pkg::ilt_result_t       step_res;
  ilt_pkg::ilt_result_t       res_q;
  logic                       in_vld_q, out_vld_q;
  logic [ilt_pkg::BYTE_W-1:0] byte_q;
  logic                       eot_q;
  logic                       out_free, advance, in_acc;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  ilt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ilt_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .text_byte_i   (byte_q),
    .end_of_text_i (eot_q),
    .cfg_i         (cfg),
    .result_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= text_byte_i;
      eot_q  <= end_of_text_i;
    end
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign byte_out_o      = res_q.byte_out;
  assign byte_role_o     = res_q.role;
  assign byte_position_o = res_q.position;
  assign section_slot_o  = res_q.sect_slot;
  assign pair_slot_o     = res_q.pair_slot;
  assign line_done_o     = res_q.line_done;
  assign line_kind_o     = res_q.kind;
  assign text_done_o     = res_q.text_done;

endmodule
